/* rtl/core/jpst_pkg.sv */
// ----------------------------------------------------------------------------
// jpst_pkg
// Shared types, codes and the byte classifier of the JSON punctuation and
// string tokenizer.
// ----------------------------------------------------------------------------
package jpst_pkg;

  localparam int POS_BITS_DEF = 16;
  localparam int FLD_W        = 16;
  localparam int Q_DEPTH      = 2;
  localparam int Q_IDX_W      = $clog2(Q_DEPTH);
  localparam int Q_CNT_W      = $clog2(Q_DEPTH + 1);

  localparam logic [FLD_W-1:0] START_LINE_RST   = 16'd1;
  localparam logic [FLD_W-1:0] START_COLUMN_RST = 16'd0;

  typedef enum logic [1:0] {
    REG_START_LINE   = 2'd0,
    REG_START_COLUMN = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_TOKEN     = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_BAD_CHAR  = 3'd2,
    ST_UNTERM    = 3'd3,
    ST_END       = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    TK_OBJ_BEGIN = 3'd0,
    TK_OBJ_END   = 3'd1,
    TK_ARR_BEGIN = 3'd2,
    TK_ARR_END   = 3'd3,
    TK_COMMA     = 3'd4,
    TK_COLON     = 3'd5,
    TK_STRING    = 3'd6,
    TK_CHAR      = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    CL_ZERO    = 3'd0,
    CL_NEWLINE = 3'd1,
    CL_SPACE   = 3'd2,
    CL_PUNCT   = 3'd3,
    CL_DQUOTE  = 3'd4,
    CL_SQUOTE  = 3'd5,
    CL_OTHER   = 3'd6
  } cls_t;

  typedef struct packed {
    cls_t  cls;
    kind_t kind;
  } item_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic item_t classify(input logic [7:0] b);
    item_t it;
    it.cls  = CL_OTHER;
    it.kind = TK_OBJ_BEGIN;
    unique case (b)
      CH_NUL:    it.cls = CL_ZERO;
      CH_LF:     it.cls = CL_NEWLINE;
      CH_TAB, CH_VT, CH_FF, CH_CR, CH_SPACE: it.cls = CL_SPACE;
      CH_DQUOTE: it.cls = CL_DQUOTE;
      CH_SQUOTE: it.cls = CL_SQUOTE;
      CH_LBRACE: begin it.cls = CL_PUNCT; it.kind = TK_OBJ_BEGIN; end
      CH_RBRACE: begin it.cls = CL_PUNCT; it.kind = TK_OBJ_END;   end
      CH_LBRACK: begin it.cls = CL_PUNCT; it.kind = TK_ARR_BEGIN; end
      CH_RBRACK: begin it.cls = CL_PUNCT; it.kind = TK_ARR_END;   end
      CH_COMMA:  begin it.cls = CL_PUNCT; it.kind = TK_COMMA;     end
      CH_COLON:  begin it.cls = CL_PUNCT; it.kind = TK_COLON;     end
      default:   it.cls = CL_OTHER;
    endcase
    return it;
  endfunction

endpackage

/* rtl/core/jpst_front.sv */
// ----------------------------------------------------------------------------
// jpst_front
// Input stage: take one text byte per beat, classify it and hold the class
// in a register until the queue takes it.
// ----------------------------------------------------------------------------
module jpst_front
  import jpst_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  output logic        push_valid,
  output item_t       push_item,
  input  logic        push_ready
);

  logic  fv_r;
  item_t item_r;

  assign in_ready   = !fv_r || push_ready;
  assign push_valid = fv_r;
  assign push_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fv_r <= 1'b1;
    end else if (push_ready) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= classify(in_text_byte);
    end
  end

endmodule

/* rtl/core/jpst_queue.sv */
// ----------------------------------------------------------------------------
// jpst_queue
// Short FIFO of classified bytes between the front and back stages.
// ----------------------------------------------------------------------------
module jpst_queue
  import jpst_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  input  item_t push_item,
  output logic  push_ready,
  output logic  pop_valid,
  output item_t pop_item,
  input  logic  pop_ready
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_IDX_W-1:0] wr_r;
  logic [Q_IDX_W-1:0] rd_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               push;
  logic               pop;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == Q_IDX_W'(Q_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_item;
    end
  end

endmodule

/* rtl/core/jpst_back.sv */
// ----------------------------------------------------------------------------
// jpst_back
// Scanner: walk the classified bytes, track line, column and lexeme length,
// and register one result per token, error or end.
// ----------------------------------------------------------------------------
module jpst_back
  import jpst_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [FLD_W-1:0] cfg_data,
  input  logic             pop_valid,
  input  item_t            pop_item,
  output logic             pop_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_token_kind,
  output logic [FLD_W-1:0] out_token_line,
  output logic [FLD_W-1:0] out_token_column,
  output logic [FLD_W-1:0] out_token_length
);

  localparam int EXT_W = (POS_BITS > FLD_W) ? POS_BITS : FLD_W;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  typedef logic [POS_BITS-1:0] pos_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STR  = 4'b0010,
    S_CHR  = 4'b0100,
    S_HALT = 4'b1000
  } state_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic pos_t clip(input logic [FLD_W-1:0] v);
    logic [EXT_W-1:0] e;
    logic [EXT_W-1:0] m;
    e = EXT_W'(v);
    m = EXT_W'(POS_MAX);
    return (e > m) ? POS_MAX : e[POS_BITS-1:0];
  endfunction

  function automatic logic [FLD_W-1:0] to_fld(input pos_t v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[FLD_W-1:0];
  endfunction

  state_t           state_r, state_nxt;
  pos_t             line_r, line_nxt;
  pos_t             col_r, col_nxt;
  pos_t             tsl_r, tsl_nxt;
  pos_t             tsc_r, tsc_nxt;
  pos_t             len_r, len_nxt;
  logic             ov_r;
  status_t          st_r, st_nxt;
  kind_t            kind_r, kind_nxt;
  logic [FLD_W-1:0] oline_r, oline_nxt;
  logic [FLD_W-1:0] ocol_r, ocol_nxt;
  logic [FLD_W-1:0] olen_r, olen_nxt;
  logic             emit;
  logic             take;
  logic             cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign pop_ready = !ov_r || out_ready;
  assign take      = pop_valid && pop_ready;

  assign out_valid        = ov_r;
  assign out_status       = st_r;
  assign out_token_kind   = kind_r;
  assign out_token_line   = oline_r;
  assign out_token_column = ocol_r;
  assign out_token_length = olen_r;

  always_comb begin
    state_nxt = state_r;
    line_nxt  = line_r;
    col_nxt   = col_r;
    tsl_nxt   = tsl_r;
    tsc_nxt   = tsc_r;
    len_nxt   = len_r;
    emit      = 1'b0;
    st_nxt    = ST_TOKEN;
    kind_nxt  = TK_OBJ_BEGIN;
    oline_nxt = to_fld(line_r);
    ocol_nxt  = to_fld(col_r);
    olen_nxt  = '0;
    if (take) begin
      unique case (state_r)
        S_IDLE: begin
          unique case (pop_item.cls)
            CL_ZERO: begin
              emit = 1'b1; st_nxt = ST_END; state_nxt = S_HALT;
            end
            CL_NEWLINE: begin
              line_nxt = sat_inc(line_r); col_nxt = '0;
            end
            CL_SPACE: col_nxt = sat_inc(col_r);
            CL_PUNCT: begin
              emit     = 1'b1;
              kind_nxt = pop_item.kind;
              olen_nxt = FLD_W'(1);
              col_nxt  = sat_inc(col_r);
            end
            CL_DQUOTE, CL_SQUOTE: begin
              tsl_nxt   = line_r;
              tsc_nxt   = col_r;
              len_nxt   = POS_BITS'(1);
              col_nxt   = sat_inc(col_r);
              state_nxt = (pop_item.cls == CL_DQUOTE) ? S_STR : S_CHR;
            end
            default: begin
              emit = 1'b1; st_nxt = ST_UNKNOWN; state_nxt = S_HALT;
            end
          endcase
        end
        S_STR: begin
          if (pop_item.cls == CL_ZERO) begin
            emit = 1'b1; st_nxt = ST_UNTERM; state_nxt = S_HALT;
          end else begin
            len_nxt = sat_inc(len_r);
            if (pop_item.cls == CL_NEWLINE) begin
              line_nxt = sat_inc(line_r); col_nxt = '0;
            end else begin
              col_nxt = sat_inc(col_r);
            end
            if (pop_item.cls == CL_DQUOTE) begin
              emit      = 1'b1;
              kind_nxt  = TK_STRING;
              oline_nxt = to_fld(tsl_r);
              ocol_nxt  = to_fld(tsc_r);
              olen_nxt  = to_fld(sat_inc(len_r));
              state_nxt = S_IDLE;
            end
          end
        end
        S_CHR: begin
          if (pop_item.cls == CL_ZERO) begin
            emit = 1'b1; st_nxt = ST_BAD_CHAR; state_nxt = S_HALT;
          end else if (pop_item.cls == CL_SQUOTE) begin
            if (len_r != POS_BITS'(2)) begin
              emit = 1'b1; st_nxt = ST_BAD_CHAR; state_nxt = S_HALT;
            end else begin
              len_nxt   = POS_BITS'(3);
              col_nxt   = sat_inc(col_r);
              emit      = 1'b1;
              kind_nxt  = TK_CHAR;
              oline_nxt = to_fld(tsl_r);
              ocol_nxt  = to_fld(tsc_r);
              olen_nxt  = FLD_W'(3);
              state_nxt = S_IDLE;
            end
          end else begin
            len_nxt = sat_inc(len_r);
            if (pop_item.cls == CL_NEWLINE) begin
              line_nxt = sat_inc(line_r); col_nxt = '0;
            end else begin
              col_nxt = sat_inc(col_r);
            end
          end
        end
        default: ;
      endcase
    end
    if (cfg_wr && cfg_index == REG_START_LINE) begin
      line_nxt = clip(cfg_data);
    end
    if (cfg_wr && cfg_index == REG_START_COLUMN) begin
      col_nxt = clip(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      line_r  <= clip(START_LINE_RST);
      col_r   <= clip(START_COLUMN_RST);
      tsl_r   <= '0;
      tsc_r   <= '0;
      len_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      line_r  <= line_nxt;
      col_r   <= col_nxt;
      tsl_r   <= tsl_nxt;
      tsc_r   <= tsc_nxt;
      len_r   <= len_nxt;
      if (take) begin
        ov_r <= emit;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      st_r    <= st_nxt;
      kind_r  <= kind_nxt;
      oline_r <= oline_nxt;
      ocol_r  <= ocol_nxt;
      olen_r  <= olen_nxt;
    end
  end

endmodule

/* rtl/core/json_punct_string_tokenizer.sv */
// ----------------------------------------------------------------------------
// json_punct_string_tokenizer
// Byte-serial tokenizer for JSON punctuation, double-quoted strings and
// single-quoted character literals, with line and column tracking.
// ----------------------------------------------------------------------------
// Takes one text byte per clock while the output is not stalled, and returns
// one result per token, error or end of text. A byte passes the classifier
// register, a two-entry queue and the scanner, whose combinational update
// of the line, column and length counters allows the one-byte-per-clock rate;
// the result for a closing byte is held in the output register. The queue
// and the output register let input and output stall independently. After
// an error or the end result the block consumes and drops bytes until reset.
// Write start_line (index 0) and start_column (index 1) while idle; a write
// loads the matching counter at once.
module json_punct_string_tokenizer
  import jpst_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
)(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [FLD_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_text_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_status,
  output logic [2:0]       out_token_kind,
  output logic [FLD_W-1:0] out_token_line,
  output logic [FLD_W-1:0] out_token_column,
  output logic [FLD_W-1:0] out_token_length
);

  logic  push_valid;
  item_t push_item;
  logic  push_ready;
  logic  pop_valid;
  item_t pop_item;
  logic  pop_ready;

  jpst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_text_byte (in_text_byte),
    .push_valid   (push_valid),
    .push_item    (push_item),
    .push_ready   (push_ready)
  );

  jpst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  jpst_back #(
    .POS_BITS (POS_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .pop_valid        (pop_valid),
    .pop_item         (pop_item),
    .pop_ready        (pop_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_column (out_token_column),
    .out_token_length (out_token_length)
  );

endmodule

/* test/jpst_token_checker.sv */
// ----------------------------------------------------------------------------
// jpst_token_checker
// Watches the configuration, text and token channels of the tokenizer,
// tracks scan state and position on its own, and compares each token beat,
// field by field, with the oldest token still due.
// ----------------------------------------------------------------------------
module jpst_token_checker
  import jpst_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [FLD_W-1:0] cfg_data,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_text_byte,
  input  logic             out_valid,
  input  logic             out_ready,
  input  logic [2:0]       out_status,
  input  logic [2:0]       out_token_kind,
  input  logic [FLD_W-1:0] out_token_line,
  input  logic [FLD_W-1:0] out_token_column,
  input  logic [FLD_W-1:0] out_token_length,
  output int               fails,
  output int               due_count
);

  typedef enum logic [1:0] {
    SCAN_GAP,
    SCAN_STR,
    SCAN_CHR,
    SCAN_HALT
  } scan_t;

  typedef struct packed {
    status_t          status;
    kind_t            kind;
    logic [FLD_W-1:0] line;
    logic [FLD_W-1:0] column;
    logic [FLD_W-1:0] length;
  } token_t;

  scan_t            mode;
  logic [FLD_W-1:0] line_pos;
  logic [FLD_W-1:0] col_pos;
  logic [FLD_W-1:0] tok_line;
  logic [FLD_W-1:0] tok_col;
  logic [FLD_W-1:0] tok_len;
  token_t           tokens_due[$];

  function automatic logic [FLD_W-1:0] bump(input logic [FLD_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  task automatic post(input status_t st, input kind_t k, input logic [FLD_W-1:0] ln,
                      input logic [FLD_W-1:0] cl, input logic [FLD_W-1:0] len);
    token_t t;
    t.status = st;
    t.kind   = k;
    t.line   = ln;
    t.column = cl;
    t.length = len;
    tokens_due.push_back(t);
  endtask

  task automatic halt_with(input status_t st);
    mode = SCAN_HALT;
    post(st, TK_OBJ_BEGIN, line_pos, col_pos, '0);
  endtask

  task automatic step_position(input logic [7:0] b);
    if (b == CH_LF) begin
      line_pos = bump(line_pos);
      col_pos  = '0;
    end else begin
      col_pos = bump(col_pos);
    end
  endtask

  task automatic open_quote(input scan_t m);
    tok_line = line_pos;
    tok_col  = col_pos;
    tok_len  = 16'd1;
    col_pos  = bump(col_pos);
    mode     = m;
  endtask

  task automatic mark(input kind_t k);
    post(ST_TOKEN, k, line_pos, col_pos, 16'd1);
    col_pos = bump(col_pos);
  endtask

  task automatic tokenize_byte(input logic [7:0] b);
    case (mode)
      SCAN_GAP: begin
        case (b)
          CH_NUL: halt_with(ST_END);
          CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: step_position(b);
          CH_LBRACE: mark(TK_OBJ_BEGIN);
          CH_RBRACE: mark(TK_OBJ_END);
          CH_LBRACK: mark(TK_ARR_BEGIN);
          CH_RBRACK: mark(TK_ARR_END);
          CH_COMMA:  mark(TK_COMMA);
          CH_COLON:  mark(TK_COLON);
          CH_DQUOTE: open_quote(SCAN_STR);
          CH_SQUOTE: open_quote(SCAN_CHR);
          default:   halt_with(ST_UNKNOWN);
        endcase
      end
      SCAN_STR: begin
        if (b == CH_NUL) begin
          halt_with(ST_UNTERM);
        end else begin
          tok_len = bump(tok_len);
          step_position(b);
          if (b == CH_DQUOTE) begin
            mode = SCAN_GAP;
            post(ST_TOKEN, TK_STRING, tok_line, tok_col, tok_len);
          end
        end
      end
      SCAN_CHR: begin
        if (b == CH_NUL) begin
          halt_with(ST_BAD_CHAR);
        end else if (b == CH_SQUOTE) begin
          if (tok_len != 16'd2) begin
            halt_with(ST_BAD_CHAR);
          end else begin
            tok_len = 16'd3;
            col_pos = bump(col_pos);
            mode    = SCAN_GAP;
            post(ST_TOKEN, TK_CHAR, tok_line, tok_col, tok_len);
          end
        end else begin
          tok_len = bump(tok_len);
          step_position(b);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    token_t t;
    if (!rst_n) begin
      mode     = SCAN_GAP;
      line_pos = START_LINE_RST;
      col_pos  = START_COLUMN_RST;
      tok_line = '0;
      tok_col  = '0;
      tok_len  = '0;
      tokens_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_due.size() == 0) begin
          $error("token beat with none due: status %0d kind %0d", out_status,
                 out_token_kind);
          fails++;
        end else begin
          t = tokens_due.pop_front();
          check_field("status", t.status, out_status);
          check_field("token_kind", t.kind, out_token_kind);
          check_field("token_line", t.line, out_token_line);
          check_field("token_column", t.column, out_token_column);
          check_field("token_length", t.length, out_token_length);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_LINE:   line_pos = cfg_data;
          REG_START_COLUMN: col_pos  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) tokenize_byte(in_text_byte);
    end
    due_count = tokens_due.size();
  end

endmodule

/* test/json_punct_string_tokenizer_tb.sv */
// ----------------------------------------------------------------------------
// json_punct_string_tokenizer_tb
// Feeds the tokenizer a directed text covering every token kind, whitespace
// and saturating positions, then random well-formed token streams under
// several start positions and random stalls on both channels, and finally
// one randomly chosen terminating case followed by bytes that must be
// dropped. A checker beside the block predicts and compares every token.
// ----------------------------------------------------------------------------
module json_punct_string_tokenizer_tb;
  import jpst_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [FLD_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_text_byte;
  logic             out_valid;
  logic             out_ready;
  logic [2:0]       out_status;
  logic [2:0]       out_token_kind;
  logic [FLD_W-1:0] out_token_line;
  logic [FLD_W-1:0] out_token_column;
  logic [FLD_W-1:0] out_token_length;

  int fails;
  int due_count;
  int sent = 0;
  bit in_burst = 1'b0;
  bit squeeze_req = 1'b0;

  json_punct_string_tokenizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_column (out_token_column),
    .out_token_length (out_token_length)
  );

  jpst_token_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_token_kind   (out_token_kind),
    .out_token_line   (out_token_line),
    .out_token_column (out_token_column),
    .out_token_length (out_token_length),
    .fails            (fails),
    .due_count        (due_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] punct_byte(input int i);
    case (i)
      0:       return CH_LBRACE;
      1:       return CH_RBRACE;
      2:       return CH_LBRACK;
      3:       return CH_RBRACK;
      4:       return CH_COMMA;
      default: return CH_COLON;
    endcase
  endfunction

  function automatic logic [7:0] space_byte(input int i);
    case (i)
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_VT;
      4:       return CH_FF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] body_byte(input logic [7:0] quote);
    logic [7:0] b;
    if ($urandom_range(0, 5) == 0) return CH_LF;
    do b = 8'($urandom_range(1, 255)); while (b == quote);
    return b;
  endfunction

  // call at a falling edge; returns at the falling edge after the beat
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
    sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [FLD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic set_position(input logic [FLD_W-1:0] ln, input logic [FLD_W-1:0] cl);
    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    write_reg(REG_START_LINE, ln);
    write_reg(REG_START_COLUMN, cl);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [FLD_W-1:0] pick_pos();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return FLD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_token();
    int n;
    if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
    case ($urandom_range(0, 9))
      0, 1, 2: send_byte(punct_byte($urandom_range(0, 5)));
      3, 4:    send_byte(space_byte($urandom_range(0, 5)));
      5, 6, 7: begin
        n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        send_byte(CH_DQUOTE);
        repeat (n) send_byte(body_byte(CH_DQUOTE));
        send_byte(CH_DQUOTE);
      end
      default: begin
        send_byte(CH_SQUOTE);
        send_byte(body_byte(CH_SQUOTE));
        send_byte(CH_SQUOTE);
      end
    endcase
  endtask

  initial begin
    int target;
    logic [7:0] b;
    bit known;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_text_byte = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_START_LINE;
    cfg_data     = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 6; i++) send_byte(punct_byte(i));
    for (int i = 0; i < 6; i++) send_byte(space_byte(i));
    send_str("\"\"");
    send_byte(CH_DQUOTE);
    send_byte(CH_LF);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(CH_DQUOTE);
    send_str("'\n'");
    send_byte(CH_SQUOTE);
    send_byte(8'hFF);
    send_byte(CH_SQUOTE);

    // saturate column, then line
    set_position(16'hFFFF, 16'hFFFE);
    send_str("[],\"ab\"\n\n{");
    set_position('0, '0);
    send_str("[:]");

    for (int ph = 0; ph < 5; ph++) begin
      set_position(pick_pos(), pick_pos());
      in_burst = ($urandom_range(0, 3) == 0);
      if (ph == 0) squeeze_req = 1'b1;
      target = sent + 170;
      while (sent < target) random_token();
    end

    in_burst = 1'b0;
    case ($urandom_range(0, 4))
      0: send_byte(CH_NUL);
      1: begin
        do begin
          b = 8'($urandom_range(1, 255));
          known = (b == CH_DQUOTE) || (b == CH_SQUOTE);
          for (int i = 0; i < 6; i++) known |= (b == punct_byte(i)) || (b == space_byte(i));
        end while (known);
        send_byte(b);
      end
      2: begin
        send_byte(CH_SQUOTE);
        repeat ($urandom_range(0, 1) * 2) send_byte(body_byte(CH_SQUOTE));
        send_byte(CH_SQUOTE);
      end
      3: begin
        send_byte(CH_SQUOTE);
        repeat ($urandom_range(0, 1)) send_byte(body_byte(CH_SQUOTE));
        send_byte(CH_NUL);
      end
      default: begin
        send_byte(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) send_byte(body_byte(CH_DQUOTE));
        send_byte(CH_NUL);
      end
    endcase
    repeat (16) send_byte(8'($urandom_range(0, 255)));

    in_valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    bit rx_burst;
    bit squeezed;
    out_ready = 1'b0;
    rx_burst  = 1'b0;
    squeezed  = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 14);
      // hold off long enough for the block to fill and stall its input
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        stall    = 300;
      end
      if ($urandom_range(0, 24) == 0) rx_burst = !rx_burst;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
